// ===== design/lfst_pkg.sv =====
// ----------------------------------------------------------------------------
// lfst_pkg
// shared types, codes and the gradient table of the factor sgd trainer
// ----------------------------------------------------------------------------
`default_nettype none

package lfst_pkg;

    localparam int NUM_ITEMS_DEF   = 1024;
    localparam int RANK_DEF        = 16;
    localparam int MAX_HISTORY_DEF = 64;

    localparam int TYPE_W  = 3;
    localparam int ITEM_W  = 10;
    localparam int POS_W   = 4;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int GRAD_W     = 16;
    localparam int GRAD_DEPTH = 256;
    localparam int GRAD_HALF  = GRAD_DEPTH / 2;

    localparam logic [CFG_DATA_W-1:0] LR_RESET  = 16'd655;
    localparam logic [CFG_DATA_W-1:0] REG_RESET = 16'd655;

    typedef enum logic [TYPE_W-1:0] {
        REQ_WR_ROW = 3'd0,
        REQ_WR_COL = 3'd1,
        REQ_PUSH   = 3'd2,
        REQ_TRAIN  = 3'd3,
        REQ_RD_ROW = 3'd4,
        REQ_RD_COL = 3'd5,
        REQ_RSVD6  = 3'd6,
        REQ_RSVD7  = 3'd7
    } req_code_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_SAT  = 2'd2
    } stat_code_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LR  = 8'd0,
        CFG_REG = 8'd1
    } cfg_code_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_WRITE,
        OP_PUSH,
        OP_READ,
        OP_READ_DONE,
        OP_HIST_RD,
        OP_HIST_LAT,
        OP_FAC_RD,
        OP_SC_MUL,
        OP_SC_ACC,
        OP_GRAD,
        OP_U1,
        OP_U2,
        OP_U3,
        OP_U4,
        OP_U5,
        OP_TRAIN_END
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   h_clr;
        logic   h_inc;
        logic   k_clr;
        logic   k_inc;
    } lfst_cmd_t;

    typedef struct packed {
        req_code_t req_type;
        logic      item_ok;
        logic      elem_ok;
        logic      hist_full;
        logic      hist_empty;
        logic      last_h;
        logic      last_k;
    } lfst_sts_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_RD_WAIT,
        S_SHRD,
        S_SHLAT,
        S_SFRD,
        S_SMUL,
        S_SACC,
        S_GRAD,
        S_UHRD,
        S_UHLAT,
        S_UFRD,
        S_U1,
        S_U2,
        S_U3,
        S_U4,
        S_U5,
        S_TEND,
        S_RESP
    } ctrl_state_t;

    typedef logic [GRAD_W-1:0] grad_tbl_t [GRAD_DEPTH];

    // restoring long division, used only while building the table
    function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[62:0], num[i]};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // magnitude 1/(1+exp(c)) per 1/16 bin of [-8,8), built at elaboration
    function automatic grad_tbl_t build_grad_tbl();
        grad_tbl_t   t;
        logic [63:0] q;
        logic [63:0] step;
        logic [63:0] d;
        logic [63:0] e;
        e    = 64'd4162825044;
        step = (e * e + 64'd2147483648) >> 32;
        q    = e;
        for (int m = 0; m < GRAD_HALF; m++)
        begin
            d = 64'd4294967296 + q;
            t[GRAD_HALF + m]     = GRAD_W'(div_u64((q << 16) + (d >> 1), d));
            t[GRAD_HALF - 1 - m] = GRAD_W'(div_u64((64'd4294967296 << 16) + (d >> 1), d));
            q = (q * step + 64'd2147483648) >> 32;
        end
        return t;
    endfunction

endpackage

`default_nettype wire

// ===== design/lfst_if.sv =====
// ----------------------------------------------------------------------------
// lfst channel interfaces
// request, response and register write channels with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface lfst_req_if;
    logic                           valid;
    logic                           ready;
    logic [lfst_pkg::TYPE_W-1:0]    req_type;
    logic [lfst_pkg::ITEM_W-1:0]    item_index;
    logic [lfst_pkg::POS_W-1:0]     factor_pos;
    logic signed [lfst_pkg::VALUE_W-1:0] factor_value;
    logic                           label_positive;

    modport source (output valid, req_type, item_index, factor_pos, factor_value,
                    label_positive, input ready);
    modport sink   (input valid, req_type, item_index, factor_pos, factor_value,
                    label_positive, output ready);
endinterface

interface lfst_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [lfst_pkg::VALUE_W-1:0] read_value;
    logic [lfst_pkg::STAT_W-1:0]         status;

    modport source (output valid, read_value, status, input ready);
    modport sink   (input valid, read_value, status, output ready);
endinterface

interface lfst_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [lfst_pkg::CFG_IDX_W-1:0]    index;
    logic [lfst_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/lfst_ram.sv =====
// ----------------------------------------------------------------------------
// lfst_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module lfst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/lfst_ctrl.sv =====
// ----------------------------------------------------------------------------
// lfst_ctrl
// request sequencer: decodes a request and steps the datapath through it
// ----------------------------------------------------------------------------
`default_nettype none

module lfst_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output lfst_pkg::lfst_cmd_t      cmd,
    input  wire lfst_pkg::lfst_sts_t sts
);
    import lfst_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '{op: OP_NONE, h_clr: 1'b0, h_inc: 1'b0, k_clr: 1'b0, k_inc: 1'b0};
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_CAPTURE;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_RESP;
                unique case (sts.req_type)
                    REQ_WR_ROW, REQ_WR_COL:
                    begin
                        if (sts.elem_ok)
                        begin
                            cmd.op = OP_WRITE;
                        end
                    end
                    REQ_PUSH:
                    begin
                        if (sts.item_ok)
                        begin
                            cmd.op = OP_PUSH;
                        end
                    end
                    REQ_RD_ROW, REQ_RD_COL:
                    begin
                        if (sts.elem_ok)
                        begin
                            cmd.op     = OP_READ;
                            state_next = S_RD_WAIT;
                        end
                    end
                    REQ_TRAIN:
                    begin
                        if (sts.item_ok && !sts.hist_empty)
                        begin
                            cmd.h_clr  = 1'b1;
                            state_next = S_SHRD;
                        end
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_RD_WAIT:
            begin
                cmd.op     = OP_READ_DONE;
                state_next = S_RESP;
            end
            // score pass
            S_SHRD:
            begin
                cmd.op     = OP_HIST_RD;
                state_next = S_SHLAT;
            end
            S_SHLAT:
            begin
                cmd.op     = OP_HIST_LAT;
                cmd.k_clr  = 1'b1;
                state_next = S_SFRD;
            end
            S_SFRD:
            begin
                cmd.op     = OP_FAC_RD;
                state_next = S_SMUL;
            end
            S_SMUL:
            begin
                cmd.op     = OP_SC_MUL;
                state_next = S_SACC;
            end
            S_SACC:
            begin
                cmd.op = OP_SC_ACC;
                if (!sts.last_k)
                begin
                    cmd.k_inc  = 1'b1;
                    state_next = S_SFRD;
                end
                else if (!sts.last_h)
                begin
                    cmd.h_inc  = 1'b1;
                    state_next = S_SHRD;
                end
                else
                begin
                    state_next = S_GRAD;
                end
            end
            S_GRAD:
            begin
                cmd.op     = OP_GRAD;
                cmd.h_clr  = 1'b1;
                state_next = S_UHRD;
            end
            // update pass
            S_UHRD:
            begin
                cmd.op     = OP_HIST_RD;
                state_next = S_UHLAT;
            end
            S_UHLAT:
            begin
                cmd.op     = OP_HIST_LAT;
                cmd.k_clr  = 1'b1;
                state_next = S_UFRD;
            end
            S_UFRD:
            begin
                cmd.op     = OP_FAC_RD;
                state_next = S_U1;
            end
            S_U1:
            begin
                cmd.op     = OP_U1;
                state_next = S_U2;
            end
            S_U2:
            begin
                cmd.op     = OP_U2;
                state_next = S_U3;
            end
            S_U3:
            begin
                cmd.op     = OP_U3;
                state_next = S_U4;
            end
            S_U4:
            begin
                cmd.op     = OP_U4;
                state_next = S_U5;
            end
            S_U5:
            begin
                cmd.op = OP_U5;
                if (!sts.last_k)
                begin
                    cmd.k_inc  = 1'b1;
                    state_next = S_UFRD;
                end
                else if (!sts.last_h)
                begin
                    cmd.h_inc  = 1'b1;
                    state_next = S_UHRD;
                end
                else
                begin
                    state_next = S_TEND;
                end
            end
            S_TEND:
            begin
                cmd.op     = OP_TRAIN_END;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/lfst_dp.sv =====
// ----------------------------------------------------------------------------
// lfst_dp
// datapath: factor and history memories, score accumulator, update arithmetic
// ----------------------------------------------------------------------------
`default_nettype none

module lfst_dp #(
    parameter int NUM_ITEMS   = lfst_pkg::NUM_ITEMS_DEF,
    parameter int RANK        = lfst_pkg::RANK_DEF,
    parameter int MAX_HISTORY = lfst_pkg::MAX_HISTORY_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire lfst_pkg::lfst_cmd_t                  cmd,
    output lfst_pkg::lfst_sts_t                       sts,
    input  wire logic [lfst_pkg::TYPE_W-1:0]          in_type,
    input  wire logic [lfst_pkg::ITEM_W-1:0]          in_item,
    input  wire logic [lfst_pkg::POS_W-1:0]           in_pos,
    input  wire logic signed [lfst_pkg::VALUE_W-1:0]  in_value,
    input  wire logic                                 in_label,
    input  wire logic                                 cfg_we,
    input  wire logic [lfst_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [lfst_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic signed [lfst_pkg::VALUE_W-1:0]       read_value,
    output logic [lfst_pkg::STAT_W-1:0]               status
);
    import lfst_pkg::*;

    localparam int DEPTH = NUM_ITEMS * RANK;
    localparam int AW    = $clog2(DEPTH);
    localparam int HW    = (MAX_HISTORY > 1) ? $clog2(MAX_HISTORY) : 1;
    localparam int CW    = $clog2(MAX_HISTORY + 1);
    localparam int KW    = (RANK > 1) ? $clog2(RANK) : 1;
    localparam grad_tbl_t GRAD_TBL = build_grad_tbl();
    localparam logic signed [65:0] ACC_MAX = 66'sd4611686018427387904;
    localparam logic signed [65:0] ACC_MIN = -66'sd4611686018427387904;
    localparam logic signed [32:0] X_MIN   = -33'sd524288;
    localparam logic signed [32:0] X_MAX   = 33'sd524287;

    // captured request
    req_code_t                type_reg;
    logic [ITEM_W-1:0]        item_reg;
    logic [POS_W-1:0]         pos_reg;
    logic signed [31:0]       val_reg;
    logic                     lab_reg;

    logic [CFG_DATA_W-1:0]    lr_reg;
    logic [CFG_DATA_W-1:0]    lam_reg;
    logic [CW-1:0]            cnt_reg;
    logic [HW-1:0]            h_reg;
    logic [KW-1:0]            k_reg;
    logic [ITEM_W-1:0]        r_reg;
    logic signed [63:0]       acc_reg;
    logic signed [16:0]       g_reg;
    logic signed [66:0]       pr_reg;
    logic signed [66:0]       pc_reg;
    logic signed [33:0]       tr_reg;
    logic signed [33:0]       tc_reg;
    logic signed [31:0]       res_reg;
    stat_code_t               st_reg;

    logic                     item_ok;
    logic                     elem_ok;
    logic [AW-1:0]            req_addr;
    logic [AW-1:0]            row_addr;
    logic [AW-1:0]            col_addr;
    logic signed [31:0]       row_rdata;
    logic signed [31:0]       col_rdata;
    logic [ITEM_W-1:0]        hist_rdata;
    logic                     row_we;
    logic                     col_we;
    logic                     fac_re;
    logic [AW-1:0]            row_waddr;
    logic [AW-1:0]            col_waddr;
    logic [31:0]              row_wdata;
    logic [31:0]              col_wdata;
    logic signed [33:0]       mr_a;
    logic signed [33:0]       mc_a;
    logic signed [32:0]       m_b;
    logic signed [66:0]       mr_p;
    logic signed [66:0]       mc_p;
    logic signed [65:0]       acc_sum;
    logic signed [63:0]       acc_clamped;
    logic                     acc_clip;
    logic signed [31:0]       v_sat;
    logic                     v_clip;
    logic signed [32:0]       x_raw;
    logic signed [32:0]       x_clamp;
    logic [19:0]              x_bias;
    logic [GRAD_W-1:0]        g_mag;
    logic signed [51:0]       row_diff;
    logic signed [51:0]       col_diff;
    logic signed [31:0]       row_new;
    logic signed [31:0]       col_new;
    logic                     row_clip;
    logic                     col_clip;

    always_comb
    begin
        item_ok  = 32'(type_reg == type_reg ? item_reg : '0) < 32'(NUM_ITEMS);
        elem_ok  = item_ok && (32'(pos_reg) < 32'(RANK));
        req_addr = AW'(32'(item_reg) * 32'(RANK) + 32'(pos_reg));
        row_addr = AW'(32'(r_reg) * 32'(RANK) + 32'(k_reg));
        col_addr = AW'(32'(item_reg) * 32'(RANK) + 32'(k_reg));
    end

    always_comb
    begin
        sts.req_type   = type_reg;
        sts.item_ok    = item_ok;
        sts.elem_ok    = elem_ok;
        sts.hist_full  = (32'(cnt_reg) == 32'(MAX_HISTORY));
        sts.hist_empty = (cnt_reg == '0);
        sts.last_h     = (32'(h_reg) + 32'd1 == 32'(cnt_reg));
        sts.last_k     = (32'(k_reg) == 32'(RANK - 1));
    end

    // memories
    always_comb
    begin
        fac_re    = (cmd.op == OP_READ) || (cmd.op == OP_FAC_RD);
        row_we    = ((cmd.op == OP_WRITE) && (type_reg == REQ_WR_ROW)) || (cmd.op == OP_U5);
        col_we    = ((cmd.op == OP_WRITE) && (type_reg == REQ_WR_COL)) || (cmd.op == OP_U5);
        row_waddr = (cmd.op == OP_WRITE) ? req_addr : row_addr;
        col_waddr = (cmd.op == OP_WRITE) ? req_addr : col_addr;
        row_wdata = (cmd.op == OP_WRITE) ? val_reg : row_new;
        col_wdata = (cmd.op == OP_WRITE) ? val_reg : col_new;
    end

    lfst_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH), .AW(AW)) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .re    (fac_re),
        .raddr ((cmd.op == OP_READ) ? req_addr : row_addr),
        .rdata (row_rdata)
    );

    lfst_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH), .AW(AW)) u_col_ram (
        .clk   (clk),
        .we    (col_we),
        .waddr (col_waddr),
        .wdata (col_wdata),
        .re    (fac_re),
        .raddr ((cmd.op == OP_READ) ? req_addr : col_addr),
        .rdata (col_rdata)
    );

    lfst_ram #(.WIDTH(ITEM_W), .DEPTH(MAX_HISTORY), .AW(HW)) u_hist_ram (
        .clk   (clk),
        .we    ((cmd.op == OP_PUSH) && !sts.hist_full),
        .waddr (cnt_reg[HW-1:0]),
        .wdata (item_reg),
        .re    (cmd.op == OP_HIST_RD),
        .raddr (h_reg),
        .rdata (hist_rdata)
    );

    // shared multipliers, operands picked by step
    always_comb
    begin
        mr_a = 34'(row_rdata);
        mc_a = 34'(col_rdata);
        m_b  = 33'(col_rdata);
        unique case (cmd.op)
            OP_U1:
            begin
                mr_a = 34'(col_rdata);
                mc_a = 34'(row_rdata);
                m_b  = 33'(g_reg);
            end
            OP_U2:
            begin
                m_b = $signed({17'b0, lam_reg});
            end
            OP_U4:
            begin
                mr_a = tr_reg;
                mc_a = tc_reg;
                m_b  = $signed({17'b0, lr_reg});
            end
            default:
            begin
                mr_a = 34'(row_rdata);
            end
        endcase
        mr_p = 67'(mr_a) * 67'(m_b);
        mc_p = 67'(mc_a) * 67'(m_b);
    end

    // score accumulate with clamp
    always_comb
    begin
        acc_sum  = 66'(acc_reg) + 66'(pr_reg >>> 16);
        acc_clip = 1'b0;
        if (acc_sum > ACC_MAX)
        begin
            acc_clamped = 64'(ACC_MAX);
            acc_clip    = 1'b1;
        end
        else if (acc_sum < ACC_MIN)
        begin
            acc_clamped = 64'(ACC_MIN);
            acc_clip    = 1'b1;
        end
        else
        begin
            acc_clamped = 64'(acc_sum);
        end
    end

    // score to gradient lookup
    always_comb
    begin
        v_clip = 1'b0;
        if (acc_reg > 64'sd2147483647)
        begin
            v_sat  = 32'sh7fffffff;
            v_clip = 1'b1;
        end
        else if (acc_reg < -64'sd2147483648)
        begin
            v_sat  = 32'sh80000000;
            v_clip = 1'b1;
        end
        else
        begin
            v_sat = 32'(acc_reg);
        end
        x_raw = lab_reg ? 33'(v_sat) : -33'(v_sat);
        if (x_raw < X_MIN)
        begin
            x_clamp = X_MIN;
        end
        else if (x_raw > X_MAX)
        begin
            x_clamp = X_MAX;
        end
        else
        begin
            x_clamp = x_raw;
        end
        x_bias = x_clamp[19:0] + 20'h80000;
        g_mag  = GRAD_TBL[x_bias[19:12]];
    end

    // element writeback with saturation
    always_comb
    begin
        row_diff = 52'(row_rdata) - 52'(pr_reg >>> 16);
        col_diff = 52'(col_rdata) - 52'(pc_reg >>> 16);
        row_clip = (row_diff > 52'sd2147483647) || (row_diff < -52'sd2147483648);
        col_clip = (col_diff > 52'sd2147483647) || (col_diff < -52'sd2147483648);
        if (row_diff > 52'sd2147483647)
        begin
            row_new = 32'sh7fffffff;
        end
        else if (row_diff < -52'sd2147483648)
        begin
            row_new = 32'sh80000000;
        end
        else
        begin
            row_new = 32'(row_diff);
        end
        if (col_diff > 52'sd2147483647)
        begin
            col_new = 32'sh7fffffff;
        end
        else if (col_diff < -52'sd2147483648)
        begin
            col_new = 32'sh80000000;
        end
        else
        begin
            col_new = 32'(col_diff);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg  <= LR_RESET;
            lam_reg <= REG_RESET;
            cnt_reg <= '0;
            h_reg   <= '0;
            k_reg   <= '0;
            st_reg  <= ST_OK;
        end
        else
        begin
            if (cfg_we && (cfg_index == CFG_LR))
            begin
                lr_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == CFG_REG))
            begin
                lam_reg <= cfg_data;
            end
            if (cmd.h_clr)
            begin
                h_reg <= '0;
            end
            else if (cmd.h_inc)
            begin
                h_reg <= h_reg + HW'(1);
            end
            if (cmd.k_clr)
            begin
                k_reg <= '0;
            end
            else if (cmd.k_inc)
            begin
                k_reg <= k_reg + KW'(1);
            end
            unique case (cmd.op)
                OP_CAPTURE:
                begin
                    st_reg <= ST_OK;
                end
                OP_PUSH:
                begin
                    if (sts.hist_full)
                    begin
                        st_reg <= ST_FULL;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end
                OP_SC_ACC:
                begin
                    if (acc_clip)
                    begin
                        st_reg <= ST_SAT;
                    end
                end
                OP_GRAD:
                begin
                    if (v_clip)
                    begin
                        st_reg <= ST_SAT;
                    end
                end
                OP_U5:
                begin
                    if (row_clip || col_clip)
                    begin
                        st_reg <= ST_SAT;
                    end
                end
                OP_TRAIN_END:
                begin
                    cnt_reg <= '0;
                end
                default:
                begin
                    st_reg <= st_reg;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_CAPTURE:
            begin
                type_reg <= req_code_t'(in_type);
                item_reg <= in_item;
                pos_reg  <= in_pos;
                val_reg  <= in_value;
                lab_reg  <= in_label;
                res_reg  <= '0;
                acc_reg  <= '0;
            end
            OP_READ_DONE:
            begin
                res_reg <= (type_reg == REQ_RD_ROW) ? row_rdata : col_rdata;
            end
            OP_HIST_LAT:
            begin
                r_reg <= hist_rdata;
            end
            OP_SC_MUL:
            begin
                pr_reg <= mr_p;
            end
            OP_SC_ACC:
            begin
                acc_reg <= acc_clamped;
            end
            OP_GRAD:
            begin
                res_reg <= v_sat;
                g_reg   <= lab_reg ? -$signed({1'b0, g_mag}) : $signed({1'b0, g_mag});
            end
            OP_U1:
            begin
                pr_reg <= mr_p;
                pc_reg <= mc_p;
            end
            OP_U2:
            begin
                tr_reg <= 34'(pr_reg >>> 16);
                tc_reg <= 34'(pc_reg >>> 16);
                pr_reg <= mr_p;
                pc_reg <= mc_p;
            end
            OP_U3:
            begin
                tr_reg <= tr_reg + 34'(pr_reg >>> 16);
                tc_reg <= tc_reg + 34'(pc_reg >>> 16);
            end
            OP_U4:
            begin
                pr_reg <= mr_p;
                pc_reg <= mc_p;
            end
            default:
            begin
                res_reg <= res_reg;
            end
        endcase
    end

    assign read_value = res_reg;
    assign status     = st_reg;

endmodule

`default_nettype wire

// ===== design/logistic_factor_sgd_trainer.sv =====
// ----------------------------------------------------------------------------
// logistic_factor_sgd_trainer
// logistic matrix factorization sgd trainer with row and column factor tables
// ----------------------------------------------------------------------------
// one request in flight; the next is taken the cycle after the result beat
// writes, pushes and rejected requests go from decode straight to the result
// beat, element reads first wait on the registered ram read; train with H
// history items runs a score pass and an update pass: one factor read per
// multiply-accumulate and six steps per element update
// reset clears history count and status, rates to 655; memories undefined
`default_nettype none

module logistic_factor_sgd_trainer #(
    parameter int NUM_ITEMS   = lfst_pkg::NUM_ITEMS_DEF,
    parameter int RANK        = lfst_pkg::RANK_DEF,
    parameter int MAX_HISTORY = lfst_pkg::MAX_HISTORY_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    lfst_req_if.sink   req,
    lfst_rsp_if.source rsp,
    lfst_cfg_if.sink   cfg
);
    import lfst_pkg::*;

    lfst_cmd_t cmd;
    lfst_sts_t sts;

    // registers take a write in any cycle
    assign cfg.ready = 1'b1;

    lfst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    lfst_dp #(
        .NUM_ITEMS   (NUM_ITEMS),
        .RANK        (RANK),
        .MAX_HISTORY (MAX_HISTORY)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_type    (req.req_type),
        .in_item    (req.item_index),
        .in_pos     (req.factor_pos),
        .in_value   (req.factor_value),
        .in_label   (req.label_positive),
        .cfg_we     (cfg.valid),
        .cfg_index  (cfg.index),
        .cfg_data   (cfg.data),
        .read_value (rsp.read_value),
        .status     (rsp.status)
    );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the logistic factor sgd trainer. Requests are
// driven through the request channel, and a bit-exact predictor in the bench
// works out every response. Results are checked in order against the
// predicted queue while both channels idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lfst_pkg::*;

    localparam int NI        = NUM_ITEMS_DEF;
    localparam int RK        = RANK_DEF;
    localparam int HMAX      = MAX_HISTORY_DEF;
    localparam int POOL      = 12;
    localparam int IDLE_MAX  = 40000;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic [STAT_W-1:0]  stat;
    } answer_t;

    logic clk;
    logic rst_n;

    lfst_req_if req ();
    lfst_rsp_if rsp ();
    lfst_cfg_if cfg ();

    logistic_factor_sgd_trainer uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    // predictor state
    int      row_f [NI*RK];
    int      col_f [NI*RK];
    bit      row_w [NI*RK];
    bit      col_w [NI*RK];
    int      hist [$];
    longint  beta_q;
    longint  lambda_q;
    longint  sigmoid_mag [GRAD_DEPTH];

    answer_t pending_answers [$];
    int      mismatches;
    int      idle_cycles;
    int      send_idle_pct;
    int      rsp_stall_pct;
    int      pool [POOL];

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // magnitude 1/(1+e^c) per 1/16 bin, upper half from e^-c, lower from 1-...
    task automatic fill_sigmoid();
        bit [63:0] e1;
        bit [63:0] e2;
        bit [63:0] q;
        bit [63:0] d;
        e1 = 64'd4162825044;
        e2 = (e1 * e1 + 64'd2147483648) >> 32;
        q  = e1;
        for (int m = 0; m < GRAD_DEPTH / 2; m++)
        begin
            d = 64'd4294967296 + q;
            sigmoid_mag[GRAD_DEPTH/2 + m]     = longint'(((q << 16) + d / 2) / d);
            sigmoid_mag[GRAD_DEPTH/2 - 1 - m] =
                longint'(((64'd4294967296 << 16) + d / 2) / d);
            q = (q * e2 + 64'd2147483648) >> 32;
        end
    endtask

    function automatic longint clip32(longint x, inout bit hit);
        if (x > 64'sd2147483647)
        begin
            hit = 1'b1;
            return 64'sd2147483647;
        end
        if (x < -64'sd2147483648)
        begin
            hit = 1'b1;
            return -64'sd2147483648;
        end
        return x;
    endfunction

    // first unwritten position of an item, -1 when the whole vector is set
    function automatic int first_gap(bit is_col, int item);
        for (int k = 0; k < RK; k++)
            if (!(is_col ? col_w[item*RK+k] : row_w[item*RK+k]))
                return k;
        return -1;
    endfunction

    function automatic answer_t train_record(int tgt, bit pos_label);
        answer_t a;
        longint  acc;
        longint  x;
        longint  g;
        longint  ro;
        longint  co;
        longint  tr;
        longint  tc;
        longint  v;
        bit      hit;
        int      r;
        acc = 0;
        hit = 1'b0;
        foreach (hist[h])
        begin
            r = hist[h];
            for (int k = 0; k < RK; k++)
            begin
                acc += (longint'(row_f[r*RK+k]) * longint'(col_f[tgt*RK+k])) >>> 16;
                if (acc > 64'sd4611686018427387904)
                begin
                    acc = 64'sd4611686018427387904;
                    hit = 1'b1;
                end
                if (acc < -64'sd4611686018427387904)
                begin
                    acc = -64'sd4611686018427387904;
                    hit = 1'b1;
                end
            end
        end
        v = clip32(acc, hit);
        x = pos_label ? v : -v;
        if (x < -524288)
            x = -524288;
        if (x > 524287)
            x = 524287;
        g = sigmoid_mag[(x + 524288) >>> 12];
        if (pos_label)
            g = -g;
        foreach (hist[h])
        begin
            r = hist[h];
            for (int k = 0; k < RK; k++)
            begin
                ro = row_f[r*RK+k];
                co = col_f[tgt*RK+k];
                tr = ((g * co) >>> 16) + ((lambda_q * ro) >>> 16);
                tc = ((g * ro) >>> 16) + ((lambda_q * co) >>> 16);
                row_f[r*RK+k]   = int'(clip32(ro - ((beta_q * tr) >>> 16), hit));
                col_f[tgt*RK+k] = int'(clip32(co - ((beta_q * tc) >>> 16), hit));
            end
        end
        hist.delete();
        a.value = VALUE_W'(v);
        a.stat  = hit ? ST_SAT : ST_OK;
        return a;
    endfunction

    task automatic apply_request(req_code_t t, int item, int pos, int val, bit lab);
        answer_t a;
        int      addr;
        addr    = item * RK + pos;
        a.value = '0;
        a.stat  = ST_OK;
        case (t)
            REQ_WR_ROW:
            begin
                row_f[addr] = val;
                row_w[addr] = 1'b1;
            end
            REQ_WR_COL:
            begin
                col_f[addr] = val;
                col_w[addr] = 1'b1;
            end
            REQ_PUSH:
                if (hist.size() < HMAX)
                    hist = {hist, item};
                else
                    a.stat = ST_FULL;
            REQ_TRAIN:  a = train_record(item, lab);
            REQ_RD_ROW: a.value = row_f[addr];
            REQ_RD_COL: a.value = col_f[addr];
            default:    ;
        endcase
        pending_answers = {pending_answers, a};
    endtask

    task automatic send(req_code_t t, int item, int pos, int val, bit lab);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid          <= 1'b1;
        req.req_type       <= t;
        req.item_index     <= ITEM_W'(item);
        req.factor_pos     <= POS_W'(pos);
        req.factor_value   <= val;
        req.label_positive <= lab;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        apply_request(t, item, pos, val, lab);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(cfg_code_t idx, int val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= CFG_DATA_W'(val);
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        if (idx == CFG_LR)
            beta_q = val;
        else
            lambda_q = val;
    endtask

    task automatic set_rates(int lr, int lam);
        drain();
        write_reg(CFG_LR, lr);
        write_reg(CFG_REG, lam);
        cfg.valid <= 1'b0;
    endtask

    // extremes of the element values, readback, unused codes, empty train
    task automatic test_directed();
        send(REQ_WR_ROW, 0, 0, 32'h7FFF_FFFF, 1'b0);
        send(REQ_WR_ROW, 0, 15, 32'h8000_0000, 1'b1);
        send(REQ_WR_COL, NI-1, 15, 32'h7FFF_FFFF, 1'b1);
        send(REQ_WR_COL, NI-1, 0, 32'h8000_0000, 1'b0);
        send(REQ_WR_COL, NI-1, 7, 32'h5555_AAAA, 1'b0);
        send(REQ_RD_ROW, 0, 0, 0, 1'b0);
        send(REQ_RD_ROW, 0, 15, -1, 1'b1);
        send(REQ_RD_COL, NI-1, 15, 0, 1'b0);
        send(REQ_RD_COL, NI-1, 0, 0, 1'b1);
        send(REQ_RD_COL, NI-1, 7, 0, 1'b0);
        send(REQ_RSVD6, 0, 0, 32'h1234_5678, 1'b1);
        send(REQ_RSVD7, NI-1, 15, -1, 1'b1);
        send(REQ_TRAIN, NI-1, 0, 0, 1'b1);
        send(REQ_TRAIN, 0, 15, 0, 1'b0);
    endtask

    // history overflow: 64 pushes fit, the next two are dropped, then a long train
    task automatic test_history_full();
        for (int k = 0; k < RK; k++)
        begin
            send(REQ_WR_ROW, 5, k, $urandom_range(0, 65535) - 32768, 1'b0);
            send(REQ_WR_ROW, 6, k, $urandom_range(0, 65535) - 32768, 1'b0);
            send(REQ_WR_COL, 9, k, $urandom_range(0, 131071) - 65536, 1'b0);
        end
        for (int h = 0; h < HMAX; h++)
            send(REQ_PUSH, (h % 3 == 0) ? 6 : 5, 0, 0, 1'b0);
        send(REQ_PUSH, 5, 0, 0, 1'b1);
        send(REQ_PUSH, NI-1, 3, -1, 1'b0);
        send(REQ_TRAIN, 9, 0, 0, 1'b0);
        send(REQ_RD_COL, 9, 4, 0, 1'b0);
    endtask

    // huge factors saturate score and updates
    task automatic test_saturation();
        for (int k = 0; k < RK; k++)
        begin
            send(REQ_WR_ROW, 1, k, 32'h7FFF_FFFF, 1'b0);
            send(REQ_WR_COL, 2, k, (k % 2) ? 32'h7FFF_FFFF : 32'h8000_0001, 1'b0);
        end
        send(REQ_PUSH, 1, 0, 0, 1'b0);
        send(REQ_PUSH, 1, 0, 0, 1'b0);
        send(REQ_TRAIN, 2, 0, 0, 1'b1);
        send(REQ_RD_ROW, 1, 3, 0, 1'b0);
        send(REQ_PUSH, 1, 0, 0, 1'b0);
        send(REQ_TRAIN, 2, 0, 0, 1'b0);
    endtask

    task automatic test_random(int n);
        int  roll;
        int  it;
        int  p;
        int  v;
        int  gap;
        bit  side;
        for (int i = 0; i < n; i++)
        begin
            roll = $urandom_range(99);
            it   = pool[$urandom_range(POOL-1)];
            p    = $urandom_range(RK-1);
            side = $urandom_range(1);
            v    = ($urandom_range(9) == 0) ? int'($urandom)
                                            : $urandom_range(0, 262143) - 131072;
            if (roll < 30)
                send(side ? REQ_WR_COL : REQ_WR_ROW, it, p, v, $urandom_range(1));
            else if (roll < 45)
            begin
                if (side ? col_w[it*RK+p] : row_w[it*RK+p])
                    send(side ? REQ_RD_COL : REQ_RD_ROW, it, p, int'($urandom),
                         $urandom_range(1));
                else
                    send(side ? REQ_WR_COL : REQ_WR_ROW, it, p, v, 1'b0);
            end
            else if (roll < 73)
            begin
                gap = first_gap(1'b0, it);
                if (gap < 0)
                    send(REQ_PUSH, it, p, v, $urandom_range(1));
                else
                    send(REQ_WR_ROW, it, gap, v, 1'b0);
            end
            else if (roll < 90)
            begin
                gap = first_gap(1'b1, it);
                if (gap < 0)
                    send(REQ_TRAIN, it, p, v, $urandom_range(1));
                else
                    send(REQ_WR_COL, it, gap, v, 1'b0);
            end
            else if (roll < 95)
                send($urandom_range(1) ? REQ_RSVD7 : REQ_RSVD6, $urandom_range(NI-1),
                     p, int'($urandom), $urandom_range(1));
            else
                send(side ? REQ_WR_COL : REQ_WR_ROW, it, p, int'($urandom), 1'b1);
        end
    endtask

    // receiver stalls
    always @(posedge clk)
        rsp.ready <= ($urandom_range(99) >= rsp_stall_pct);

    // response check against the oldest prediction
    always @(posedge clk)
    begin
        if (rsp.valid && rsp.ready)
        begin
            if (pending_answers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: value %h status %0d",
                             rsp.read_value, rsp.status);
            end
            else
            begin
                answer_t a;
                a = pending_answers.pop_front();
                if (rsp.read_value !== a.value || rsp.status !== a.stat)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: value exp %h got %h, status exp %0d got %0d",
                                 a.value, rsp.read_value, a.stat, rsp.status);
                end
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) ||
            (cfg.valid && cfg.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_MAX)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        req.valid          = 1'b0;
        req.req_type       = REQ_WR_ROW;
        req.item_index     = '0;
        req.factor_pos     = '0;
        req.factor_value   = '0;
        req.label_positive = 1'b0;
        cfg.valid          = 1'b0;
        cfg.index          = CFG_LR;
        cfg.data           = '0;
        rsp.ready          = 1'b0;
        mismatches         = 0;
        idle_cycles        = 0;
        send_idle_pct      = 0;
        rsp_stall_pct      = 0;
        beta_q             = LR_RESET;
        lambda_q           = REG_RESET;
        fill_sigmoid();
        pool[0] = 0;
        pool[1] = NI - 1;
        for (int i = 2; i < POOL; i++)
            pool[i] = $urandom_range(10, NI - 2);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_saturation();
        test_history_full();

        set_rates(655, 655);
        test_random(330);
        send_idle_pct = 52;
        set_rates(65535, 0);
        test_random(330);
        send_idle_pct = 0;
        rsp_stall_pct = 52;
        set_rates(0, 65535);
        test_random(330);
        send_idle_pct = 23;
        rsp_stall_pct = 23;
        set_rates($urandom_range(65535), $urandom_range(65535));
        test_random(330);

        drain();
        if (mismatches == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
